@@ hw/rtl/limit_order_book_matcher_core_defines.svh @@
// Assertion macros for the order book matcher.
// Used by the top level only; needs a signal named clock and one named reset.
`ifndef LIMIT_ORDER_BOOK_MATCHER_CORE_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_CORE_DEFINES_SVH

// same-cycle implication
`define LOBM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LOBM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/lobm_pkg.sv @@
// Shared constants, types and helpers for the order book matcher.
// No dependencies.
`default_nettype none
package lobm_pkg;
   localparam int LEVELS_PER_SIDE  = 8;
   localparam int ORDERS_PER_LEVEL = 4;
   localparam int PRICE_BITS       = 20;
   localparam int QTY_BITS         = 16;
   localparam int ID_BITS          = 32;

   localparam int LVL_W  = (LEVELS_PER_SIDE > 1) ? $clog2(LEVELS_PER_SIDE) : 1;
   localparam int SCNT_W = $clog2(LEVELS_PER_SIDE + 1);
   localparam int SLOT_W = (ORDERS_PER_LEVEL > 1) ? $clog2(ORDERS_PER_LEVEL) : 1;
   localparam int OCNT_W = $clog2(ORDERS_PER_LEVEL + 1);
   localparam int NUM_SLOTS = 2 * LEVELS_PER_SIDE * ORDERS_PER_LEVEL;
   localparam int ADDR_W = $clog2(NUM_SLOTS);
   localparam int SLOT_DATA_W = ID_BITS + QTY_BITS;

   typedef logic [PRICE_BITS-1:0] price_type;
   typedef logic [QTY_BITS-1:0]   qty_type;
   typedef logic [ID_BITS-1:0]    id_type;
   typedef logic [LVL_W-1:0]      lvl_type;
   typedef logic [SCNT_W-1:0]     scnt_type;
   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [OCNT_W-1:0]     ocnt_type;
   typedef logic [ADDR_W-1:0]     addr_type;

   typedef struct packed {
      price_type price;
      ocnt_type  cnt;
      slot_type  head;
      lvl_type   phys;
   } level_type;

   localparam logic [1:0] STAT_ACKED    = 2'd0;
   localparam logic [1:0] STAT_FILLED   = 2'd1;
   localparam logic [1:0] STAT_PARTIAL  = 2'd2;
   localparam logic [1:0] STAT_REJECTED = 2'd3;

   localparam logic KIND_FILL   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   function automatic addr_type slot_addr(logic s, lvl_type phys, slot_type slot);
      slot_addr = ADDR_W'((int'(s) * LEVELS_PER_SIDE + int'(phys)) * ORDERS_PER_LEVEL
                          + int'(slot));
   endfunction
endpackage
`default_nettype wire

@@ hw/rtl/lobm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lobm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/limit_order_book_matcher_core.sv @@
// Order book matcher top level: price-level registers, sequencer, output register.
// Depends on lobm_pkg, lobm_ram and limit_order_book_matcher_core_defines.svh.
//
// Usage:
//  req_* carries one limit order per transaction; req_stall is high while an
//  order is in work, so one order is handled at a time.
//  rsp_* carries the results: one fill per resting order touched (rsp_kind 0),
//  then one final report (rsp_kind 1, rsp_last 1).
//  Sequence: each matched level gets a check step, each fill a read of the
//  slot RAM (one read port), then an update; the insert and report follow.
//  The output register holds a result while rsp_stall is high; the sequencer
//  waits for it, so nothing is dropped.
//  Reset empties both sides of the book and clears the last trade price;
//  slot contents are not cleared, only read within the level counts.
`default_nettype none
`include "limit_order_book_matcher_core_defines.svh"
module limit_order_book_matcher_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_side,
   input  wire lobm_pkg::price_type req_limit_price,
   input  wire lobm_pkg::qty_type   req_order_qty,
   input  wire lobm_pkg::id_type    req_order_id,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_kind,
   output lobm_pkg::id_type         rsp_resting_id,
   output lobm_pkg::price_type      rsp_fill_price,
   output lobm_pkg::qty_type        rsp_fill_qty,
   output logic [1:0]               rsp_status,
   output lobm_pkg::qty_type        rsp_exec_qty,
   output lobm_pkg::price_type      rsp_best_bid,
   output lobm_pkg::price_type      rsp_best_ask,
   output lobm_pkg::price_type      rsp_last_trade_price,
   output logic                     rsp_last
);
   import lobm_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_RD    = 6'b000100,
      S_FILL  = 6'b001000,
      S_INS   = 6'b010000,
      S_REP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      side_ff, side_in;
   price_type lim_ff, lim_in;
   qty_type   rem_ff, rem_in;
   qty_type   exec_ff, exec_in;
   id_type    id_ff, id_in;
   logic      matched_ff, matched_in;
   logic [1:0] status_ff, status_in;
   price_type last_trade_ff, last_trade_in;
   level_type rank_ff [2][LEVELS_PER_SIDE];
   level_type rank_in [2][LEVELS_PER_SIDE];
   scnt_type  nlev_ff [2];
   scnt_type  nlev_in [2];

   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_kind_ff, rsp_kind_in;
   id_type    rsp_id_ff, rsp_id_in;
   price_type rsp_fprice_ff, rsp_fprice_in;
   qty_type   rsp_fqty_ff, rsp_fqty_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   qty_type   rsp_exec_ff, rsp_exec_in;
   price_type rsp_bid_ff, rsp_bid_in;
   price_type rsp_ask_ff, rsp_ask_in;
   price_type rsp_ltp_ff, rsp_ltp_in;
   logic      rsp_last_ff, rsp_last_in;

   logic                   wr_en, rd_en;
   addr_type               wr_addr, rd_addr;
   logic [SLOT_DATA_W-1:0] wr_data, rd_data;

   lobm_ram #(.WIDTH(SLOT_DATA_W), .DEPTH(NUM_SLOTS)) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   logic out_free;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      logic      opp;
      level_type top;
      qty_type   q, take, rem_new;
      logic      pop;
      ocnt_type  cnt_new;
      scnt_type  n, pos;
      logic      exist;
      level_type at;
      logic [OCNT_W:0] tsum;
      slot_type  tail;
      lvl_type   pos_i;

      state_in      = state_ff;
      side_in       = side_ff;
      lim_in        = lim_ff;
      rem_in        = rem_ff;
      exec_in       = exec_ff;
      id_in         = id_ff;
      matched_in    = matched_ff;
      status_in     = status_ff;
      last_trade_in = last_trade_ff;
      rank_in       = rank_ff;
      nlev_in       = nlev_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_fprice_in = rsp_fprice_ff;
      rsp_fqty_in   = rsp_fqty_ff;
      rsp_status_in = rsp_status_ff;
      rsp_exec_in   = rsp_exec_ff;
      rsp_bid_in    = rsp_bid_ff;
      rsp_ask_in    = rsp_ask_ff;
      rsp_ltp_in    = rsp_ltp_ff;
      rsp_last_in   = rsp_last_ff;

      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      rd_en   = 1'b0;

      opp     = !side_ff;
      top     = rank_ff[opp][0];
      rd_addr = slot_addr(opp, top.phys, top.head);
      q       = rd_data[QTY_BITS-1:0];
      take    = (q < rem_ff) ? q : rem_ff;
      rem_new = rem_ff - take;
      pop     = (q == take);
      cnt_new = pop ? top.cnt - OCNT_W'(1) : top.cnt;

      // insert position: levels ahead of the limit form a prefix of the ranks
      n   = nlev_ff[side_ff];
      pos = '0;
      for (int r = 0; r < LEVELS_PER_SIDE; r++) begin
         if (SCNT_W'(r) < n &&
             (side_ff ? (rank_ff[side_ff][r].price < lim_ff)
                      : (rank_ff[side_ff][r].price > lim_ff))) begin
            pos = pos + SCNT_W'(1);
         end
      end
      pos_i = LVL_W'(pos);
      exist = (pos < n) && (rank_ff[side_ff][pos_i].price == lim_ff);
      at    = rank_ff[side_ff][pos_i];
      tsum  = (OCNT_W+1)'(at.head) + (OCNT_W+1)'(at.cnt);
      if (tsum >= (OCNT_W+1)'(ORDERS_PER_LEVEL)) begin
         tsum = tsum - (OCNT_W+1)'(ORDERS_PER_LEVEL);
      end
      tail = SLOT_W'(tsum);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               side_in    = req_side;
               lim_in     = req_limit_price;
               rem_in     = req_order_qty;
               id_in      = req_order_id;
               exec_in    = '0;
               matched_in = 1'b0;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (rem_ff != '0 && nlev_ff[opp] != '0 &&
                (side_ff ? (top.price >= lim_ff) : (top.price <= lim_ff))) begin
               matched_in    = 1'b1;
               last_trade_in = top.price;
               state_in      = S_RD;
            end else begin
               state_in = S_INS;
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            state_in = S_FILL;
         end
         S_FILL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_FILL;
               rsp_id_in     = rd_data[SLOT_DATA_W-1:QTY_BITS];
               rsp_fprice_in = top.price;
               rsp_fqty_in   = take;
               rsp_status_in = '0;
               rsp_exec_in   = '0;
               rsp_bid_in    = '0;
               rsp_ask_in    = '0;
               rsp_ltp_in    = '0;
               rsp_last_in   = 1'b0;
               rem_in  = rem_new;
               exec_in = exec_ff + take;
               if (pop) begin
                  rank_in[opp][0].cnt  = cnt_new;
                  rank_in[opp][0].head = (top.head == SLOT_W'(ORDERS_PER_LEVEL - 1))
                                         ? '0 : top.head + SLOT_W'(1);
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = rd_addr;
                  wr_data = {rd_data[SLOT_DATA_W-1:QTY_BITS], q - take};
               end
               if (rem_new != '0 && cnt_new != '0) begin
                  state_in = S_RD;
               end else begin
                  if (cnt_new == '0) begin
                     // drop best level; its physical block goes to the free tail
                     for (int r = 0; r < LEVELS_PER_SIDE; r++) begin
                        if (SCNT_W'(r) + SCNT_W'(1) < nlev_ff[opp]) begin
                           rank_in[opp][r] = rank_ff[opp][r+1 < LEVELS_PER_SIDE ?
                                                          r+1 : r];
                        end else if (SCNT_W'(r) + SCNT_W'(1) == nlev_ff[opp]) begin
                           rank_in[opp][r]     = top;
                           rank_in[opp][r].cnt = '0;
                        end
                     end
                     nlev_in[opp] = nlev_ff[opp] - SCNT_W'(1);
                  end
                  state_in = S_CHECK;
               end
            end
         end
         S_INS: begin
            state_in = S_REP;
            if (rem_ff == '0) begin
               status_in = STAT_FILLED;
            end else if (exist) begin
               if (at.cnt < OCNT_W'(ORDERS_PER_LEVEL)) begin
                  wr_en   = 1'b1;
                  wr_addr = slot_addr(side_ff, at.phys, tail);
                  wr_data = {id_ff, rem_ff};
                  rank_in[side_ff][pos_i].cnt = at.cnt + OCNT_W'(1);
                  status_in = matched_ff ? STAT_PARTIAL : STAT_ACKED;
               end else begin
                  status_in = STAT_REJECTED;
               end
            end else if (n < SCNT_W'(LEVELS_PER_SIDE)) begin
               wr_en   = 1'b1;
               wr_addr = slot_addr(side_ff, rank_ff[side_ff][LVL_W'(n)].phys, '0);
               wr_data = {id_ff, rem_ff};
               for (int r = 0; r < LEVELS_PER_SIDE; r++) begin
                  if (SCNT_W'(r) == pos) begin
                     rank_in[side_ff][r].price = lim_ff;
                     rank_in[side_ff][r].cnt   = OCNT_W'(1);
                     rank_in[side_ff][r].head  = '0;
                     rank_in[side_ff][r].phys  = rank_ff[side_ff][LVL_W'(n)].phys;
                  end else if (SCNT_W'(r) > pos && SCNT_W'(r) <= n) begin
                     rank_in[side_ff][r] = rank_ff[side_ff][r > 0 ? r-1 : r];
                  end
               end
               nlev_in[side_ff] = n + SCNT_W'(1);
               status_in = matched_ff ? STAT_PARTIAL : STAT_ACKED;
            end else begin
               status_in = STAT_REJECTED;
            end
         end
         S_REP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_REPORT;
               rsp_id_in     = '0;
               rsp_fprice_in = '0;
               rsp_fqty_in   = '0;
               rsp_status_in = status_ff;
               rsp_exec_in   = exec_ff;
               rsp_bid_in    = (nlev_ff[0] != '0) ? rank_ff[0][0].price : '0;
               rsp_ask_in    = (nlev_ff[1] != '0) ? rank_ff[1][0].price : '0;
               rsp_ltp_in    = last_trade_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         last_trade_ff <= '0;
         for (int s = 0; s < 2; s++) begin
            nlev_ff[s] <= '0;
            for (int r = 0; r < LEVELS_PER_SIDE; r++) begin
               rank_ff[s][r].price <= '0;
               rank_ff[s][r].cnt   <= '0;
               rank_ff[s][r].head  <= '0;
               rank_ff[s][r].phys  <= LVL_W'(r);
            end
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_trade_ff <= last_trade_in;
         rank_ff       <= rank_in;
         nlev_ff       <= nlev_in;
      end
      side_ff       <= side_in;
      lim_ff        <= lim_in;
      rem_ff        <= rem_in;
      exec_ff       <= exec_in;
      id_ff         <= id_in;
      matched_ff    <= matched_in;
      status_ff     <= status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_fprice_ff <= rsp_fprice_in;
      rsp_fqty_ff   <= rsp_fqty_in;
      rsp_status_ff <= rsp_status_in;
      rsp_exec_ff   <= rsp_exec_in;
      rsp_bid_ff    <= rsp_bid_in;
      rsp_ask_ff    <= rsp_ask_in;
      rsp_ltp_ff    <= rsp_ltp_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = rsp_kind_ff;
   assign rsp_resting_id       = rsp_id_ff;
   assign rsp_fill_price       = rsp_fprice_ff;
   assign rsp_fill_qty         = rsp_fqty_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_exec_qty         = rsp_exec_ff;
   assign rsp_best_bid         = rsp_bid_ff;
   assign rsp_best_ask         = rsp_ask_ff;
   assign rsp_last_trade_price = rsp_ltp_ff;
   assign rsp_last             = rsp_last_ff;

   `LOBM_ASSERT_NOW(a_fill_has_rem, state_ff == S_FILL, rem_ff != '0, "fill with nothing left")
   `LOBM_ASSERT_NOW(a_best_nonempty, nlev_ff[0] != '0, rank_ff[0][0].cnt != '0, "empty best bid")
   `LOBM_ASSERT_NEXT(a_rd_to_fill, state_ff == S_RD, state_ff == S_FILL, "read not followed by fill")
endmodule
`default_nettype wire

@@ tb/tb_limit_order_book_matcher_core.sv @@
// Self-checking testbench for limit_order_book_matcher_core: price-time matching of limit orders.
// Depends on lobm_pkg and the core RTL; a built-in book model predicts fills and final reports.
`timescale 1ns / 100ps
`default_nettype none
module tb_limit_order_book_matcher_core;
   import lobm_pkg::*;

   localparam int N_LVL = 2 * LEVELS_PER_SIDE;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic      side;
      price_type price;
      qty_type   qty;
      id_type    id;
   } order_t;

   typedef struct packed {
      logic       kind;
      id_type     resting_id;
      price_type  fill_price;
      qty_type    fill_qty;
      logic [1:0] status;
      qty_type    exec_qty;
      price_type  best_bid;
      price_type  best_ask;
      price_type  last_trade_price;
      logic       last;
   } result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_side = 1'b0;
   price_type req_limit_price = '0;
   qty_type req_order_qty = '0;
   id_type req_order_id = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_kind;
   id_type rsp_resting_id;
   price_type rsp_fill_price;
   qty_type rsp_fill_qty;
   logic [1:0] rsp_status;
   qty_type rsp_exec_qty;
   price_type rsp_best_bid;
   price_type rsp_best_ask;
   price_type rsp_last_trade_price;
   logic rsp_last;

   limit_order_book_matcher_core u_dut (.*);

   always #4 clock = ~clock;

   // book model: levels best first per side
   price_type bk_price [N_LVL];
   int        bk_cnt   [N_LVL];
   int        side_cnt [2];
   id_type    bk_id    [N_LVL][ORDERS_PER_LEVEL];
   qty_type   bk_qty   [N_LVL][ORDERS_PER_LEVEL];
   price_type last_px;

   order_t  pending_orders[$];
   result_t expected_results[$];
   int      mismatches = 0;
   int      cycles = 0;
   bit      quiet = 0;
   int      hold_off = 0;

   function automatic void copy_level(int d, int s);
      bk_price[d] = bk_price[s];
      bk_cnt[d] = bk_cnt[s];
      for (int k = 0; k < ORDERS_PER_LEVEL; k++) begin
         bk_id[d][k] = bk_id[s][k];
         bk_qty[d][k] = bk_qty[s][k];
      end
   endfunction

   function automatic bit rest_order(int s, price_type p, qty_type q, id_type id);
      int base, n, pos, lv;
      base = s * LEVELS_PER_SIDE;
      n = side_cnt[s];
      pos = 0;
      while (pos < n && (s == 0 ? bk_price[base+pos] > p : bk_price[base+pos] < p))
         pos++;
      if (pos < n && bk_price[base+pos] == p) begin
         lv = base + pos;
         if (bk_cnt[lv] >= ORDERS_PER_LEVEL) return 0;
         bk_id[lv][bk_cnt[lv]] = id;
         bk_qty[lv][bk_cnt[lv]] = q;
         bk_cnt[lv]++;
         return 1;
      end
      if (n >= LEVELS_PER_SIDE) return 0;
      for (int l = n; l > pos; l--) copy_level(base + l, base + l - 1);
      lv = base + pos;
      bk_price[lv] = p;
      bk_cnt[lv] = 1;
      bk_id[lv][0] = id;
      bk_qty[lv][0] = q;
      side_cnt[s] = n + 1;
      return 1;
   endfunction

   function automatic void predict_matches(order_t o);
      int opp, top, n;
      qty_type rem, exec_q, take;
      bit matched;
      result_t r;
      price_type lp;
      opp = o.side ? 0 : 1;
      top = opp * LEVELS_PER_SIDE;
      rem = o.qty;
      exec_q = '0;
      matched = 0;
      while (rem > 0 && side_cnt[opp] > 0) begin
         lp = bk_price[top];
         if (o.side == 1'b0 ? lp > o.price : lp < o.price) break;
         matched = 1;
         while (rem > 0 && bk_cnt[top] > 0) begin
            take = bk_qty[top][0] < rem ? bk_qty[top][0] : rem;
            r = '0;
            r.kind = KIND_FILL;
            r.resting_id = bk_id[top][0];
            r.fill_price = lp;
            r.fill_qty = take;
            expected_results.insert(expected_results.size(), r);
            rem -= take;
            exec_q += take;
            bk_qty[top][0] -= take;
            if (bk_qty[top][0] == 0) begin
               for (int k = 0; k + 1 < bk_cnt[top]; k++) begin
                  bk_id[top][k] = bk_id[top][k+1];
                  bk_qty[top][k] = bk_qty[top][k+1];
               end
               bk_cnt[top]--;
            end
         end
         last_px = lp;
         if (bk_cnt[top] == 0) begin
            n = side_cnt[opp];
            for (int l = 0; l + 1 < n; l++) copy_level(top + l, top + l + 1);
            bk_cnt[top + n - 1] = 0;
            side_cnt[opp] = n - 1;
         end
      end
      r = '0;
      r.kind = KIND_REPORT;
      if (rem == 0) r.status = STAT_FILLED;
      else if (rest_order(o.side, o.price, rem, o.id))
         r.status = matched ? STAT_PARTIAL : STAT_ACKED;
      else r.status = STAT_REJECTED;
      r.exec_qty = exec_q;
      r.best_bid = side_cnt[0] ? bk_price[0] : '0;
      r.best_ask = side_cnt[1] ? bk_price[LEVELS_PER_SIDE] : '0;
      r.last_trade_price = last_px;
      r.last = 1'b1;
      expected_results.insert(expected_results.size(), r);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
      mismatches++;
   endtask

   task automatic add_order(logic s, price_type p, qty_type q, id_type id);
      order_t o;
      o.side = s; o.price = p; o.qty = q; o.id = id;
      pending_orders.insert(pending_orders.size(), o);
   endtask

   // idle pattern: ~6% gaps except in quiet stretch
   function automatic bit gap();
      return !quiet && ($urandom_range(99) < 6);
   endfunction

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (pending_orders.size() > 0 && !gap()) begin
               order_t o;
               o = pending_orders.pop_front();
               predict_matches(o);
               req_valid <= 1'b1;
               req_side <= o.side;
               req_limit_price <= o.price;
               req_order_qty <= o.qty;
               req_order_id <= o.id;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= gap();
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_kind, 0);
         end else begin
            result_t e;
            e = expected_results.pop_front();
            if (rsp_kind !== e.kind) report_mismatch("kind", rsp_kind, e.kind);
            if (rsp_resting_id !== e.resting_id)
               report_mismatch("resting_id", rsp_resting_id, e.resting_id);
            if (rsp_fill_price !== e.fill_price)
               report_mismatch("fill_price", rsp_fill_price, e.fill_price);
            if (rsp_fill_qty !== e.fill_qty) report_mismatch("fill_qty", rsp_fill_qty, e.fill_qty);
            if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_exec_qty !== e.exec_qty) report_mismatch("exec_qty", rsp_exec_qty, e.exec_qty);
            if (rsp_best_bid !== e.best_bid) report_mismatch("best_bid", rsp_best_bid, e.best_bid);
            if (rsp_best_ask !== e.best_ask) report_mismatch("best_ask", rsp_best_ask, e.best_ask);
            if (rsp_last_trade_price !== e.last_trade_price)
               report_mismatch("last_trade_price", rsp_last_trade_price, e.last_trade_price);
            if (rsp_last !== e.last) report_mismatch("last", rsp_last, e.last);
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_orders.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      price_type mid;
      price_type px;
      for (int i = 0; i < N_LVL; i++) begin
         bk_cnt[i] = 0; bk_price[i] = '0;
      end
      side_cnt[0] = 0; side_cnt[1] = 0;
      last_px = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, zero qty, price zero, full level, full side
      add_order(1'b0, 20'd0, 16'd5, 32'h0);
      add_order(1'b1, 20'hFFFFF, 16'hFFFF, 32'hFFFFFFFF);
      add_order(1'b0, 20'd100, 16'd0, 32'h11);
      for (int i = 0; i < 5; i++)
         add_order(1'b0, 20'd500, qty_type'(10 + i), id_type'(32'h100 + i));
      for (int i = 0; i < 9; i++)
         add_order(1'b1, price_type'(1000 + i), 16'd7, id_type'(32'h200 + i));
      add_order(1'b1, 20'd1, 16'd30, 32'h300);       // fills against the bid level at 500
      add_order(1'b0, 20'hFFFFF, 16'hFFFF, 32'h301); // takes the asks at 1000 to 1006 and part of FFFFF
      add_order(1'b1, 20'd1, 16'd2, 32'hAAAA5555);
      add_order(1'b1, 20'd0, 16'd1, 32'h5555AAAA);
      wait_drained();

      // random: orders clustered near a mid price so they cross often
      for (int i = 0; i < 360; i++) begin
         if (i == 120) begin
            wait_drained();          // sender pause until all results have come
            hold_off = 400;          // long receiver hold-off
         end
         quiet = (i >= 200 && i < 260);
         mid = 20'd5000;
         if ($urandom_range(19) == 0) px = price_type'($urandom_range(20'hFFFFF, 0));
         else px = price_type'(int'(mid) + int'($urandom_range(12)) - 6);
         add_order(1'($urandom_range(1)), px,
                   ($urandom_range(9) == 0) ? qty_type'($urandom) : qty_type'($urandom_range(40)),
                   $urandom);
         while (pending_orders.size() > 4) @(posedge clock);
      end
      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
